// ----- rtl/tape_machine_interpreter_top_macros.svh -----
// Assertion helpers for the asserting RTL file, tape_machine_interpreter_top.
`ifndef TAPE_MACHINE_INTERPRETER_TOP_MACROS_SVH
`define TAPE_MACHINE_INTERPRETER_TOP_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst is high.
`define TMI_ASSERT_HOLDS(label, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst is high.
`define TMI_ASSERT_NEXT(label, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error(msg);

`endif

// ----- rtl/tmi_pkg.sv -----
package tmi_pkg;

  localparam int PROG_DEPTH = 4096;
  localparam int TAPE_CELLS = 32768;

  localparam int PA_W = $clog2(PROG_DEPTH);   // program store address
  localparam int PC_W = PA_W + 1;              // counts up to PROG_DEPTH
  localparam int DP_W = $clog2(TAPE_CELLS);   // tape address

  localparam int OP_W       = 2;
  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 16;
  localparam int OUT_USER_W = 1;

  typedef enum logic [OP_W-1:0] {
    OP_LOAD    = 2'd0,
    OP_STEP    = 2'd1,
    OP_RESTART = 2'd2
  } op_t;

  // command characters
  localparam logic [7:0] CMD_RIGHT = 8'h3E;  // >
  localparam logic [7:0] CMD_LEFT  = 8'h3C;  // <
  localparam logic [7:0] CMD_INC   = 8'h2B;  // +
  localparam logic [7:0] CMD_DEC   = 8'h2D;  // -
  localparam logic [7:0] CMD_OUT   = 8'h2E;  // .
  localparam logic [7:0] CMD_IN    = 8'h2C;  // ,
  localparam logic [7:0] CMD_OPEN  = 8'h5B;  // [
  localparam logic [7:0] CMD_CLOSE = 8'h5D;  // ]

endpackage

// ----- rtl/tape_machine_interpreter_top.sv -----
// Channel   Dir  tdata (low bit up)                                  tuser
// s_axis    in   program_char[7:0] input_valid[8] input_value[16:9]   operation[1:0]
// m_axis    out  out_byte[7:0] waiting_input[8] halted[9]              out_valid[0]
//
// Flow: a load or a no-op request finishes in the dispatch state; a step goes
// on through execute, and a bracket scan walks the program one character at a
// time (the single read port of the program store sets that pace).
// Reset and restart: the tape is cleared one cell per cycle, all TAPE_CELLS
// (32768) cells, during which no request is accepted; a restart then gives a result.
// Stalls: a result waiting on m_tready sits in the output register and the next
// request is taken; a second result parks behind it and holds s_tready low until
// m_tready frees the output register.
`include "tape_machine_interpreter_top_macros.svh"

module tape_machine_interpreter_top (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  // program_char[7:0], input_valid[8], input_value[16:9], zero fill
  input  logic [tmi_pkg::IN_DATA_W-1:0]   s_tdata,
  // operation[1:0]
  input  logic [tmi_pkg::OP_W-1:0]        s_tuser,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // out_byte[7:0], waiting_input[8], halted[9], zero fill
  output logic [tmi_pkg::OUT_DATA_W-1:0]  m_tdata,
  // out_valid[0]
  output logic [tmi_pkg::OUT_USER_W-1:0]  m_tuser
);
  import tmi_pkg::*;

  typedef enum logic [2:0] {
    S_CLEAR,     // sweep zeros through the tape
    S_IDLE,      // take a request
    S_DISPATCH,  // decode operation, issue memory reads
    S_EXEC,      // run the fetched command on the fetched cell
    S_FWD,       // walk forward for the matching ']'
    S_BWD,       // walk backward for the matching '['
    S_HOLD       // result parked behind a stalled output
  } state_t;

  state_t state, state_next;

  // architectural state
  logic [PC_W-1:0] pc, pc_next;
  logic [PC_W-1:0] len, len_next;
  logic [DP_W-1:0] dp, dp_next;

  // sequencer registers
  logic [PC_W-1:0] scan_addr, scan_next;
  logic [PC_W-1:0] depth, depth_next;
  logic [DP_W-1:0] clr_addr, clr_next;
  logic            clr_reply, clr_reply_next;

  // latched request
  op_t        item_op;
  logic [7:0] item_char;
  logic       item_valid;
  logic [7:0] item_value;

  // parked result
  logic       res_valid, res_wait, res_halted;
  logic [7:0] res_byte;

  // memories
  logic [7:0]      prog_mem [PROG_DEPTH];
  logic [7:0]      tape_mem [TAPE_CELLS];
  logic            prog_we;
  logic [PA_W-1:0] prog_raddr;
  logic [7:0]      prog_rdata;
  logic            tape_we;
  logic [DP_W-1:0] tape_addr;
  logic [7:0]      tape_wdata;
  logic [7:0]      tape_rdata;

  // finishing a request
  logic       finish, out_free;
  logic       fin_valid, fin_wait, fin_halted;
  logic [7:0] fin_byte;

  logic [PC_W-1:0] pc_inc, scan_inc, depth_fwd, depth_bwd;

  assign s_tready = (state == S_IDLE);
  assign out_free = !m_tvalid || m_tready;
  assign pc_inc   = pc + PC_W'(1);
  assign scan_inc = scan_addr + PC_W'(1);

  // bracket depth after the character just read during a scan
  always_comb begin
    depth_fwd = depth;
    depth_bwd = depth;
    if (prog_rdata == CMD_OPEN) begin
      depth_fwd = depth + PC_W'(1);
      depth_bwd = depth - PC_W'(1);
    end else if (prog_rdata == CMD_CLOSE) begin
      depth_fwd = depth - PC_W'(1);
      depth_bwd = depth + PC_W'(1);
    end
  end

  always_comb begin
    state_next     = state;
    pc_next        = pc;
    len_next       = len;
    dp_next        = dp;
    scan_next      = scan_addr;
    depth_next     = depth;
    clr_next       = clr_addr;
    clr_reply_next = clr_reply;
    prog_we        = 1'b0;
    prog_raddr     = pc[PA_W-1:0];
    tape_we        = 1'b0;
    tape_addr      = dp;
    tape_wdata     = tape_rdata;
    finish         = 1'b0;
    fin_valid      = 1'b0;
    fin_byte       = 8'd0;
    fin_wait       = 1'b0;

    case (state)
      S_CLEAR: begin
        tape_we    = 1'b1;
        tape_addr  = clr_addr;
        tape_wdata = 8'd0;
        if (clr_addr == DP_W'(TAPE_CELLS - 1)) begin
          clr_next = '0;
          if (clr_reply) begin
            clr_reply_next = 1'b0;
            finish         = 1'b1;
          end else begin
            state_next = S_IDLE;
          end
        end else begin
          clr_next = clr_addr + DP_W'(1);
        end
      end

      S_IDLE: begin
        if (s_tvalid) begin
          state_next = S_DISPATCH;
        end
      end

      S_DISPATCH: begin
        case (item_op)
          OP_LOAD: begin
            // drop the character once the store is full
            if (len < PC_W'(PROG_DEPTH)) begin
              prog_we  = 1'b1;
              len_next = len + PC_W'(1);
            end
            finish = 1'b1;
          end
          OP_STEP: begin
            // reads of prog[pc] and tape[dp] go out on the default addresses
            if (pc < len) begin
              state_next = S_EXEC;
            end else begin
              finish = 1'b1;
            end
          end
          OP_RESTART: begin
            pc_next        = '0;
            dp_next        = '0;
            clr_next       = '0;
            clr_reply_next = 1'b1;
            state_next     = S_CLEAR;
          end
          default: begin
            finish = 1'b1;
          end
        endcase
      end

      S_EXEC: begin
        pc_next = pc_inc;
        finish  = 1'b1;
        case (prog_rdata)
          CMD_RIGHT: begin
            dp_next = (dp == DP_W'(TAPE_CELLS - 1)) ? '0 : dp + DP_W'(1);
          end
          CMD_LEFT: begin
            dp_next = (dp == '0) ? DP_W'(TAPE_CELLS - 1) : dp - DP_W'(1);
          end
          CMD_INC: begin
            tape_we    = 1'b1;
            tape_wdata = tape_rdata + 8'd1;
          end
          CMD_DEC: begin
            tape_we    = 1'b1;
            tape_wdata = tape_rdata - 8'd1;
          end
          CMD_OUT: begin
            fin_valid = 1'b1;
            fin_byte  = tape_rdata;
          end
          CMD_IN: begin
            if (item_valid) begin
              tape_we    = 1'b1;
              tape_wdata = item_value;
            end else begin
              fin_wait = 1'b1;
              pc_next  = pc;
            end
          end
          CMD_OPEN: begin
            if (tape_rdata == 8'd0 && pc_inc < len) begin
              finish     = 1'b0;
              pc_next    = pc;
              scan_next  = pc_inc;
              depth_next = PC_W'(1);
              prog_raddr = pc_inc[PA_W-1:0];
              state_next = S_FWD;
            end
          end
          CMD_CLOSE: begin
            if (pc != '0) begin
              finish     = 1'b0;
              pc_next    = pc;
              scan_next  = pc - PC_W'(1);
              depth_next = PC_W'(1);
              prog_raddr = scan_next[PA_W-1:0];
              state_next = S_BWD;
            end
          end
          default: begin
          end
        endcase
      end

      S_FWD: begin
        if (depth_fwd == '0) begin
          pc_next = scan_inc;
          finish  = 1'b1;
        end else if (scan_inc >= len) begin
          pc_next = pc_inc;       // unmatched: act as a no-op
          finish  = 1'b1;
        end else begin
          scan_next  = scan_inc;
          depth_next = depth_fwd;
          prog_raddr = scan_inc[PA_W-1:0];
        end
      end

      S_BWD: begin
        if (depth_bwd == '0) begin
          pc_next = scan_addr;
          finish  = 1'b1;
        end else if (scan_addr == '0) begin
          pc_next = pc_inc;       // unmatched: act as a no-op
          finish  = 1'b1;
        end else begin
          scan_next  = scan_addr - PC_W'(1);
          depth_next = depth_bwd;
          prog_raddr = scan_next[PA_W-1:0];
        end
      end

      S_HOLD: begin
        if (m_tready) begin
          state_next = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase

    // park the result when the output register is still occupied
    if (finish) begin
      state_next = out_free ? S_IDLE : S_HOLD;
    end
  end

  assign fin_halted = (pc_next >= len_next);

  // program store: write at the fill point, read every cycle
  always_ff @(posedge clk) begin
    if (prog_we) begin
      prog_mem[len[PA_W-1:0]] <= item_char;
    end
    prog_rdata <= prog_mem[prog_raddr];
  end

  // tape: single port, read-first
  always_ff @(posedge clk) begin
    if (tape_we) begin
      tape_mem[tape_addr] <= tape_wdata;
    end
    tape_rdata <= tape_mem[tape_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      pc        <= '0;
      len       <= '0;
      dp        <= '0;
      clr_addr  <= '0;
      clr_reply <= 1'b0;
      m_tvalid  <= 1'b0;
    end else begin
      state     <= state_next;
      pc        <= pc_next;
      len       <= len_next;
      dp        <= dp_next;
      clr_addr  <= clr_next;
      clr_reply <= clr_reply_next;

      if (finish && out_free) begin
        m_tvalid <= 1'b1;
        m_tdata  <= {6'd0, fin_halted, fin_wait, fin_byte};
        m_tuser  <= fin_valid;
      end else if (state == S_HOLD && m_tready) begin
        m_tvalid <= 1'b1;
        m_tdata  <= {6'd0, res_halted, res_wait, res_byte};
        m_tuser  <= res_valid;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end

    scan_addr <= scan_next;
    depth     <= depth_next;

    if (s_tvalid && s_tready) begin
      item_op    <= op_t'(s_tuser);
      item_char  <= s_tdata[7:0];
      item_valid <= s_tdata[8];
      item_value <= s_tdata[16:9];
    end

    if (finish) begin
      res_valid  <= fin_valid;
      res_byte   <= fin_byte;
      res_wait   <= fin_wait;
      res_halted <= fin_halted;
    end
  end

  // the program counter never runs past the loaded program
  `TMI_ASSERT_HOLDS(a_pc_in_program, 1'b1, pc <= len, "pc beyond program length")
  // a forward scan only reads loaded characters
  `TMI_ASSERT_HOLDS(a_fwd_in_program, state == S_FWD, scan_addr < len, "scan past program")
  // a result without output carries a zero byte
  `TMI_ASSERT_HOLDS(a_byte_zero, m_tvalid && !m_tuser[0], m_tdata[7:0] == 8'd0,
                    "stray output byte")
  // a restart request starts a tape sweep from cell zero
  `TMI_ASSERT_NEXT(a_restart_clears, state == S_DISPATCH && item_op == OP_RESTART,
                   state == S_CLEAR && clr_addr == '0 && pc == '0,
                   "restart did not start a tape sweep")

endmodule

// ----- tb/tape_machine_interpreter_top_tb.sv -----
`timescale 1ns / 100ps

module tape_machine_interpreter_top_tb;
  import tmi_pkg::*;

  // Operation code the block must treat as a no-op.
  localparam logic [1:0] OP_UNUSED = 2'd3;

  localparam int RANDOM_ITEMS = 480;
  localparam int STEP_BUDGET  = 40;      // steps spent on one segment before moving on
  localparam int RESTART_CAP  = 6;       // each restart costs a full tape clear
  localparam int HOLD_CYCLES  = 800;     // long receiver hold-off
  localparam int IDLE_LIMIT   = 150000;  // tape clear plus receiver hold-off, with wide margin

  typedef struct packed {
    logic       out_valid;
    logic [7:0] out_byte;
    logic       waiting;
    logic       halted;
  } tape_out_t;

  // Tracks the machine state as requests are accepted and holds the
  // results still owed by the block.
  class tape_run_tracker;
    logic [7:0]  code_mem [PROG_DEPTH];
    logic [7:0]  cells [TAPE_CELLS];
    int unsigned code_len;
    int unsigned pc;
    int unsigned dp;
    tape_out_t   pending_outputs[$];
    int unsigned fail_count;

    function new();
      foreach (code_mem[i]) code_mem[i] = 8'd0;
      clear_tape();
      code_len = 0;
      pc = 0;
      dp = 0;
      fail_count = 0;
    endfunction

    function void clear_tape();
      foreach (cells[i]) cells[i] = 8'd0;
    endfunction

    function bit is_halted();
      return pc >= code_len;
    endfunction

    function void note_request(logic [1:0] op, logic [7:0] ch, logic iv, logic [7:0] ival);
      tape_out_t   res;
      int unsigned nxt;
      int unsigned depth;
      int unsigned j;
      logic [7:0]  c;
      res = '0;
      case (op)
        OP_LOAD: begin
          if (code_len < PROG_DEPTH) begin
            code_mem[code_len] = ch;
            code_len++;
          end
        end
        OP_STEP: begin
          if (pc < code_len) begin
            nxt = pc + 1;
            case (code_mem[pc])
              CMD_RIGHT: dp = (dp == TAPE_CELLS - 1) ? 0 : dp + 1;
              CMD_LEFT:  dp = (dp == 0) ? TAPE_CELLS - 1 : dp - 1;
              CMD_INC:   cells[dp] = cells[dp] + 8'd1;
              CMD_DEC:   cells[dp] = cells[dp] - 8'd1;
              CMD_OUT: begin
                res.out_valid = 1'b1;
                res.out_byte  = cells[dp];
              end
              CMD_IN: begin
                if (iv) begin
                  cells[dp] = ival;
                end else begin
                  res.waiting = 1'b1;
                  nxt = pc;
                end
              end
              CMD_OPEN: begin
                if (cells[dp] == 8'd0) begin
                  depth = 1;
                  for (j = pc + 1; j < code_len; j++) begin
                    c = code_mem[j];
                    if (c == CMD_OPEN) depth++;
                    else if (c == CMD_CLOSE) depth--;
                    if (depth == 0) begin
                      nxt = j + 1;
                      break;
                    end
                  end
                end
              end
              CMD_CLOSE: begin
                depth = 1;
                j = pc;
                while (j > 0) begin
                  j--;
                  c = code_mem[j];
                  if (c == CMD_OPEN) depth--;
                  else if (c == CMD_CLOSE) depth++;
                  if (depth == 0) begin
                    nxt = j;
                    break;
                  end
                end
              end
              default: ;
            endcase
            pc = nxt;
          end
        end
        OP_RESTART: begin
          pc = 0;
          dp = 0;
          clear_tape();
        end
        default: ;
      endcase
      res.halted = is_halted();
      pending_outputs = {pending_outputs, res};
    endfunction

    function void check_result(logic ov, logic [7:0] ob, logic wi, logic hl);
      tape_out_t want;
      if (pending_outputs.size() == 0) begin
        fail_count++;
        $error("result with nothing outstanding: out_valid %0d out_byte %0d %s %0d %s %0d",
               ov, ob, "waiting_input", wi, "halted", hl);
        return;
      end
      want = pending_outputs.pop_front();
      if (ov !== want.out_valid) begin
        fail_count++;
        $error("out_valid: expected %0d, got %0d", want.out_valid, ov);
      end
      if (ob !== want.out_byte) begin
        fail_count++;
        $error("out_byte: expected %0d, got %0d", want.out_byte, ob);
      end
      if (wi !== want.waiting) begin
        fail_count++;
        $error("waiting_input: expected %0d, got %0d", want.waiting, wi);
      end
      if (hl !== want.halted) begin
        fail_count++;
        $error("halted: expected %0d, got %0d", want.halted, hl);
      end
    endfunction
  endclass

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [IN_DATA_W-1:0]   s_tdata = '0;
  logic [OP_W-1:0]        s_tuser = '0;
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [OUT_DATA_W-1:0]  m_tdata;
  logic [OUT_USER_W-1:0]  m_tuser;

  tape_run_tracker tracker = new();

  int burst_left   = 0;
  int sent_count   = 0;
  int hold_asks    = 0;
  int holds_served = 0;
  int hold_left    = 0;
  int mode_left    = 0;
  int stall_pct    = 0;
  int quiet_cycles = 0;

  tape_machine_interpreter_top dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Offer one request and hold it until the block takes it. The sender runs
  // in bursts: at the start of each burst drop valid for a random gap, and
  // leave some bursts without any gap at all.
  task automatic send_request(input logic [1:0] op, input logic [7:0] ch,
                              input logic iv, input logic [7:0] ival);
    int gap;
    gap = 0;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
    end
    burst_left--;
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    // tdata: program_char[7:0], input_valid[8], input_value[16:9], zero fill
    s_tdata  <= {7'd0, ival, iv, ch};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    tracker.note_request(op, ch, iv, ival);
    sent_count++;
  endtask

  task automatic load_code(input logic [7:0] code[$]);
    foreach (code[i])
      send_request(OP_LOAD, code[i], 1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
  endtask

  // Step until the program runs off its end or the budget is used up; most
  // steps carry a valid input byte so that ',' moves on quickly.
  task automatic step_run(input int budget);
    int n;
    n = 0;
    while (!tracker.is_halted() && n < budget) begin
      send_request(OP_STEP, 8'($urandom_range(0, 255)), $urandom_range(0, 4) != 0,
                   8'($urandom_range(0, 255)));
      n++;
    end
  endtask

  // Drop valid and hold off until every outstanding result has come back.
  task automatic drain_results();
    s_tvalid <= 1'b0;
    while (tracker.pending_outputs.size() != 0) @(posedge clk);
  endtask

  // Any character that is not one of the eight commands.
  function automatic logic [7:0] filler_char();
    logic [7:0] c;
    do c = 8'($urandom_range(0, 255));
    while (c inside {CMD_RIGHT, CMD_LEFT, CMD_INC, CMD_DEC, CMD_OUT, CMD_IN,
                     CMD_OPEN, CMD_CLOSE});
    return c;
  endfunction

  // Build one program segment with balanced brackets: a straight run of
  // commands, a counted loop, or a loop with an inner clearing loop. Every
  // loop counts its own cell down, so each one ends.
  function automatic void build_segment(ref logic [7:0] code[$], input int kind);
    code.delete();
    case (kind)
      0: begin
        repeat ($urandom_range(3, 8)) begin
          case ($urandom_range(0, 9))
            0, 1:    code = {code, CMD_RIGHT};
            2, 3:    code = {code, CMD_LEFT};
            4, 5:    code = {code, CMD_INC};
            6:       code = {code, CMD_DEC};
            7:       code = {code, CMD_OUT};
            8:       code = {code, CMD_IN};
            default: code = {code, filler_char()};
          endcase
        end
      end
      1: begin
        code = {CMD_OPEN, CMD_DEC, CMD_CLOSE};
        repeat ($urandom_range(1, 4)) code = {code, CMD_INC};
        code = {code, CMD_OPEN, CMD_RIGHT};
        repeat ($urandom_range(0, 2)) code = {code, CMD_INC};
        code = {code, CMD_OUT, CMD_LEFT, CMD_DEC, CMD_CLOSE};
      end
      default: begin
        code = {CMD_OPEN, CMD_DEC, CMD_CLOSE};
        repeat ($urandom_range(1, 3)) code = {code, CMD_INC};
        code = {code, CMD_OPEN, CMD_RIGHT, CMD_INC, CMD_OPEN, CMD_DEC, CMD_CLOSE,
                CMD_OUT, CMD_LEFT, CMD_DEC, CMD_CLOSE};
      end
    endcase
  endfunction

  // Receiver: check every accepted result, and drive ready from a stall
  // pattern whose duty is redrawn whenever mode_left runs out. A hold request
  // from the stimulus side forces ready low for a long stretch.
  always @(posedge clk) begin
    if (m_tvalid && m_tready)
      // tdata: out_byte[7:0], waiting_input[8], halted[9]; tuser: out_valid[0]
      tracker.check_result(m_tuser[0], m_tdata[7:0], m_tdata[8], m_tdata[9]);
    if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      m_tready  <= 1'b0;
    end else if (holds_served != hold_asks) begin
      holds_served <= holds_served + 1;
      hold_left    <= HOLD_CYCLES;
      m_tready     <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        mode_left <= $urandom_range(20, 200);
        case ($urandom_range(0, 2))
          0:       stall_pct <= 0;
          1:       stall_pct <= 30;
          default: stall_pct <= 70;
        endcase
      end else begin
        mode_left <= mode_left - 1;
      end
      m_tready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  // Watchdog: end the run if nothing moves on either side for too long.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == IDLE_LIMIT) begin
      $display("tape_machine_interpreter_top: mismatch");
      $finish;
    end
  end

  initial begin
    logic [7:0] code[$];
    int         pick;
    int         directed_end;
    int         restarts_left;
    bit         hold_done;
    bit         pause_done;

    hold_done  = 1'b0;
    pause_done = 1'b0;
    restarts_left = RESTART_CAP;

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Unused operation and a step on an empty program: both just report halted.
    send_request(OP_UNUSED, 8'hA5, 1'b1, 8'h5A);
    send_request(OP_STEP, 8'h00, 1'b0, 8'h00);

    // Two no-op characters at the extremes, an unmatched ']', pointer wrap
    // both ways, cell wrap both ways with output, ',' without and with
    // input, and finally a '[' on a zero cell with nothing to match.
    code = {8'h00, 8'hFF, CMD_CLOSE, CMD_LEFT, CMD_RIGHT, CMD_DEC, CMD_OUT, CMD_INC,
            CMD_IN, CMD_OUT, CMD_INC, CMD_OPEN};
    load_code(code);
    repeat (8) send_request(OP_STEP, 8'hFF, 1'b1, 8'($urandom_range(0, 255)));
    send_request(OP_STEP, 8'h00, 1'b0, 8'h00);   // ',' stalls
    send_request(OP_STEP, 8'h00, 1'b1, 8'hFF);   // ',' takes the byte
    repeat (3) send_request(OP_STEP, 8'h00, 1'b1, 8'h00);
    send_request(OP_STEP, 8'h00, 1'b1, 8'h00);   // step while halted
    send_request(OP_RESTART, 8'h00, 1'b0, 8'h00);
    directed_end = sent_count;

    // Random part: mostly well-formed segments stepped until they end or the budget is spent,
    // some left half run so later loads land mid-run, plus noise and a few restarts.
    while (sent_count < directed_end + RANDOM_ITEMS) begin
      if (!hold_done && sent_count >= directed_end + 150) begin
        hold_asks++;   // receiver holds off while the sender keeps offering
        hold_done = 1'b1;
      end
      if (!pause_done && sent_count >= directed_end + 300) begin
        drain_results();
        pause_done = 1'b1;
      end
      pick = $urandom_range(0, 99);
      if (pick < 65) begin
        build_segment(code, $urandom_range(0, 2));
        load_code(code);
        step_run(STEP_BUDGET);
      end else if (pick < 80) begin
        build_segment(code, 0);
        load_code(code);
        step_run($urandom_range(1, 4));
      end else if (pick < 96) begin
        repeat ($urandom_range(1, 4)) begin
          case ($urandom_range(0, 2))
            0: send_request(OP_UNUSED, 8'($urandom_range(0, 255)),
                            1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
            1: send_request(OP_LOAD, filler_char(), 1'($urandom_range(0, 1)),
                            8'($urandom_range(0, 255)));
            default: send_request(OP_STEP, 8'($urandom_range(0, 255)),
                                  1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
          endcase
        end
      end else if (restarts_left > 0) begin
        restarts_left--;
        send_request(OP_RESTART, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                     8'($urandom_range(0, 255)));
        step_run(STEP_BUDGET);
      end
    end

    // Restart once more and run the program from the top.
    send_request(OP_RESTART, 8'h00, 1'b0, 8'h00);
    step_run(STEP_BUDGET);

    drain_results();
    repeat (50) @(posedge clk);
    if (tracker.fail_count == 0)
      $display("tape_machine_interpreter_top: match");
    else
      $display("tape_machine_interpreter_top: mismatch");
    $finish;
  end

endmodule
